>>> rtl/core/fst_pkg.sv
package fst_pkg;

	localparam int SLOTS = 8;
	localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	typedef logic [SLOT_W-1:0] slot_t;

	typedef enum logic [2:0] {
		CMD_ALLOC    = 3'd0,
		CMD_FIND_IDX = 3'd1,
		CMD_FIND_ID  = 3'd2,
		CMD_REMOVE   = 3'd3,
		CMD_AT_POS   = 3'd4,
		CMD_CLEAR    = 3'd5
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_FULL      = 2'd2
	} status_t;

	typedef struct packed {
		logic [2:0]  cmd;
		logic [7:0]  entry_index;
		logic [63:0] entry_id;
		logic [3:0]  position;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [3:0]  slot;
		logic [7:0]  found_index;
		logic [63:0] found_id;
		logic [4:0]  valid_count;
	} rsp_t;

	// table update requested by the lookup
	typedef struct packed {
		logic        wr;
		logic        rm;
		logic        clr;
		slot_t       slot;
		logic [7:0]  index;
	} upd_t;

	typedef struct packed {
		logic  hit;
		slot_t slot;
	} sel_t;

	// lowest set bit
	function automatic sel_t first_set(input logic [SLOTS-1:0] v);
		sel_t r;
		r = '0;
		for (int k = SLOTS - 1; k >= 0; k--) begin
			if (v[k]) begin
				r.hit = 1'b1;
				r.slot = SLOT_W'(k);
			end
		end
		return r;
	endfunction

endpackage

>>> rtl/core/fst_lookup.sv
module fst_lookup
	import fst_pkg::*;
(
	input  req_t        req,
	input  logic [SLOTS-1:0] slot_valid,
	input  logic [7:0]  slot_index [SLOTS],
	input  logic [63:0] slot_id [SLOTS],
	output rsp_t        rsp,
	output upd_t        upd
);

	logic [SLOTS-1:0] match_idx;
	logic [SLOTS-1:0] match_id;
	logic [SLOTS-1:0] pos_hit;
	logic [SLOTS-1:0] idx_free;
	logic [SLOTS-1:0] next_valid;
	logic [4:0]       run_cnt;
	logic [4:0]       cnt;
	sel_t             free_sel;
	sel_t             new_sel;
	sel_t             sel;

	always_comb begin
		run_cnt = '0;
		for (int k = 0; k < SLOTS; k++) begin
			match_idx[k] = slot_valid[k] && (slot_index[k] == req.entry_index)
				&& (req.entry_index != 8'd0);
			match_id[k] = slot_valid[k] && (slot_id[k] == req.entry_id);
			// k-th slot is at ordinal run_cnt among valid slots
			pos_hit[k] = slot_valid[k] && (run_cnt == {1'b0, req.position});
			run_cnt = run_cnt + 5'(slot_valid[k]);
		end
	end

	// candidate index c+1 is free when no valid slot holds it
	always_comb begin
		for (int c = 0; c < SLOTS; c++) begin
			idx_free[c] = 1'b1;
			for (int k = 0; k < SLOTS; k++) begin
				if (slot_valid[k] && slot_index[k] == 8'(c + 1)) begin
					idx_free[c] = 1'b0;
				end
			end
		end
	end

	assign free_sel = first_set(~slot_valid);
	assign new_sel = first_set(idx_free);

	always_comb begin
		upd = '0;
		sel = '0;
		rsp = '0;
		rsp.status = ST_NOT_FOUND;
		case (req.cmd)
			CMD_ALLOC: begin
				if (free_sel.hit) begin
					upd.wr = 1'b1;
					upd.slot = free_sel.slot;
					upd.index = 8'(new_sel.slot) + 8'd1;
				end else begin
					rsp.status = ST_FULL;
				end
			end
			CMD_FIND_IDX: sel = first_set(match_idx);
			CMD_FIND_ID:  sel = first_set(match_id);
			CMD_REMOVE: begin
				sel = first_set(match_idx);
				upd.rm = sel.hit;
				upd.slot = sel.slot;
			end
			CMD_AT_POS: sel = first_set(pos_hit);
			CMD_CLEAR: begin
				upd.clr = 1'b1;
				rsp.status = ST_OK;
			end
			default: ;
		endcase

		if (upd.wr) begin
			rsp.status = ST_OK;
			rsp.slot = 4'(upd.slot);
			rsp.found_index = upd.index;
			rsp.found_id = req.entry_id;
		end else if (sel.hit) begin
			rsp.status = ST_OK;
			rsp.slot = 4'(sel.slot);
			rsp.found_index = slot_index[sel.slot];
			rsp.found_id = slot_id[sel.slot];
		end

		next_valid = slot_valid;
		if (upd.wr) begin
			next_valid[upd.slot] = 1'b1;
		end
		if (upd.rm) begin
			next_valid[upd.slot] = 1'b0;
		end
		if (upd.clr) begin
			next_valid = '0;
		end
		cnt = '0;
		for (int k = 0; k < SLOTS; k++) begin
			cnt = cnt + 5'(next_valid[k]);
		end
		rsp.valid_count = cnt;
	end

endmodule

>>> rtl/core/fabric_slot_table.sv
// Slot table with allocate, find by index or identifier, remove, n-th entry and
// clear commands. Each request item produces exactly one response item, which
// passes from the request register to the response register; one item can be
// accepted every cycle while the response side is not stalling, since the
// whole lookup (parallel compares and priority picks over the slot registers)
// is combinational between the request and response registers, and the table
// is updated at the edge that loads the response, so the next item sees it.
// Index 0 never matches; failed commands return zero slot, index and identifier.
module fabric_slot_table
	import fst_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	req_t             req_s1;
	logic             req_valid_s1;
	rsp_t             rsp_q;
	logic             rsp_valid_q;
	logic [SLOTS-1:0] valid_q;
	logic [7:0]       index_q [SLOTS];
	logic [63:0]      id_q [SLOTS];
	rsp_t             lk_rsp;
	upd_t             lk_upd;
	logic             advance;

	fst_lookup u_lookup (
		.req        (req_s1),
		.slot_valid (valid_q),
		.slot_index (index_q),
		.slot_id    (id_q),
		.rsp        (lk_rsp),
		.upd        (lk_upd)
	);

	assign advance = req_valid_s1 && (!rsp_valid_q || !rsp_stall);
	assign req_stall = req_valid_s1 && !advance;
	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid_s1 <= 1'b0;
			rsp_valid_q <= 1'b0;
			valid_q <= '0;
		end else begin
			if (!req_stall) begin
				req_valid_s1 <= req_valid;
			end
			if (advance) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			if (advance) begin
				if (lk_upd.clr) begin
					valid_q <= '0;
				end else if (lk_upd.wr) begin
					valid_q[lk_upd.slot] <= 1'b1;
				end else if (lk_upd.rm) begin
					valid_q[lk_upd.slot] <= 1'b0;
				end
			end
		end
	end

	// payload registers; contents of invalid slots are never observed
	always_ff @(posedge clk) begin
		if (!req_stall && req_valid) begin
			req_s1 <= req;
		end
		if (advance) begin
			rsp_q <= lk_rsp;
			if (lk_upd.wr) begin
				index_q[lk_upd.slot] <= lk_upd.index;
				id_q[lk_upd.slot] <= req_s1.entry_id;
			end
		end
	end

	a_count_tracks_table: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> rsp_q.valid_count == 5'($countones(valid_q)))
		else $error("response count differs from table occupancy");

	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		advance && req_s1.cmd == CMD_CLEAR |=> valid_q == '0)
		else $error("clear left valid slots");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && rsp_q.status != ST_OK |->
			rsp_q.found_index == 8'd0 && rsp_q.found_id == 64'd0 && rsp_q.slot == 4'd0)
		else $error("failed response carries entry data");

	a_stall_only_when_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> req_valid_s1 && rsp_valid_q)
		else $error("request stalled with free pipeline");

endmodule
